/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the flood alarm RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hw/rtl/fac_pkg.sv */
// Types, constants and helper functions of the flood alarm controller.
`default_nettype none
package fac_pkg;

	localparam int ADC_BITS_DEF = 12;
	localparam int ADC_W        = 12;
	localparam int DIST_W       = 9;
	localparam int ECHO_W       = 15;
	localparam int MS_W         = 16;
	localparam int PCT_W        = 7;
	localparam int PROD_W       = 24;
	localparam int QUO_W        = 8;
	localparam int NUM_W        = 19;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;

	localparam logic [PROD_W-1:0] ECHO_NUM        = 24'd343;
	localparam logic [PROD_W-1:0] CM_DEN          = 24'd20000;
	localparam logic [PCT_W-1:0]  SOIL_DANGER_PCT = 7'd80;
	localparam logic [PCT_W-1:0]  SOIL_WARN_PCT   = 7'd50;
	localparam logic [PCT_W-1:0]  PCT_MAX         = 7'd100;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_DANGER_DIST = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WARN_DIST   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RAIN_HEAVY  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RAIN_LIGHT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SOIL_DRY    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SOIL_WET    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_TONE_MS     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_MS      = 3'd7;

	// Hazard levels.
	localparam logic [1:0] LVL_SAFE   = 2'd0;
	localparam logic [1:0] LVL_WARN   = 2'd1;
	localparam logic [1:0] LVL_DANGER = 2'd2;

	// Rain classes.
	localparam logic [1:0] RAIN_NONE  = 2'd0;
	localparam logic [1:0] RAIN_MOD   = 2'd1;
	localparam logic [1:0] RAIN_HEAVY = 2'd2;

	// Alarm sequence steps.
	localparam logic [2:0] ALM_START = 3'd0;
	localparam logic [2:0] ALM_HIGH  = 3'd1;
	localparam logic [2:0] ALM_GAP1  = 3'd2;
	localparam logic [2:0] ALM_LOW   = 3'd3;
	localparam logic [2:0] ALM_GAP2  = 3'd4;

	typedef struct packed {
		logic [DIST_W-1:0] danger_distance_cm;
		logic [DIST_W-1:0] warn_distance_cm;
		logic [ADC_W-1:0]  rain_heavy_level;
		logic [ADC_W-1:0]  rain_light_level;
		logic [ADC_W-1:0]  soil_dry_reading;
		logic [ADC_W-1:0]  soil_wet_reading;
		logic [MS_W-1:0]   tone_ms;
		logic [MS_W-1:0]   gap_ms;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic upd;
	} fac_cmd_t;

	typedef struct packed {
		logic div_last;
	} fac_sts_t;

	// Water is closer than limit cm: echo * 0.0343 / 2 < limit, done exactly.
	function automatic logic below_cm(logic [ECHO_W-1:0] echo, logic [DIST_W-1:0] limit);
		logic [PROD_W-1:0] lhs;
		logic [PROD_W-1:0] rhs;
		lhs = PROD_W'(echo) * ECHO_NUM;
		rhs = PROD_W'(limit) * CM_DEN;
		return (echo != '0) && (lhs < rhs);
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/fac_cfg_regs.sv */
// Configuration register file of the flood alarm controller.
`default_nettype none
module fac_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [fac_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [fac_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output fac_pkg::cfg_t                         cfg
);

	fac_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.danger_distance_cm <= 9'd45;
			cfg_q.warn_distance_cm   <= 9'd55;
			cfg_q.rain_heavy_level   <= 12'd1500;
			cfg_q.rain_light_level   <= 12'd2500;
			cfg_q.soil_dry_reading   <= 12'd3175;
			cfg_q.soil_wet_reading   <= 12'd2000;
			cfg_q.tone_ms            <= 16'd600;
			cfg_q.gap_ms             <= 16'd100;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fac_pkg::CFG_DANGER_DIST: cfg_q.danger_distance_cm <= cfg_wdata[fac_pkg::DIST_W-1:0];
				fac_pkg::CFG_WARN_DIST:   cfg_q.warn_distance_cm   <= cfg_wdata[fac_pkg::DIST_W-1:0];
				fac_pkg::CFG_RAIN_HEAVY:  cfg_q.rain_heavy_level   <= cfg_wdata[fac_pkg::ADC_W-1:0];
				fac_pkg::CFG_RAIN_LIGHT:  cfg_q.rain_light_level   <= cfg_wdata[fac_pkg::ADC_W-1:0];
				fac_pkg::CFG_SOIL_DRY:    cfg_q.soil_dry_reading   <= cfg_wdata[fac_pkg::ADC_W-1:0];
				fac_pkg::CFG_SOIL_WET:    cfg_q.soil_wet_reading   <= cfg_wdata[fac_pkg::ADC_W-1:0];
				fac_pkg::CFG_TONE_MS:     cfg_q.tone_ms            <= cfg_wdata;
				fac_pkg::CFG_GAP_MS:      cfg_q.gap_ms             <= cfg_wdata;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

/* hw/rtl/fac_ctrl.sv */
// Control state machine of the flood alarm controller.
`default_nettype none
`include "assert_macros.svh"
module fac_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          in_mode,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	input  wire fac_pkg::fac_sts_t sts,
	output fac_pkg::fac_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIV  = 4'b0010,
		S_UPD  = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_n;
	logic   accept;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign accept    = in_valid && (state_q == S_IDLE);

	always_comb begin
		state_n      = state_q;
		cmd.load     = 1'b0;
		cmd.div_step = 1'b0;
		cmd.upd      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					// Samples need the soil division; ticks go straight to the update.
					state_n  = in_mode ? S_DIV : S_UPD;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_n = S_UPD;
				end
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				state_n = S_OUT;
			end
			S_OUT: begin
				if (!out_stall) begin
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	`ASSERT_NEXT(a_div_to_upd, clk, arst_n, (state_q == S_DIV) && sts.div_last, state_q == S_UPD, "division end did not start the update")
	`ASSERT_NEXT(a_upd_to_out, clk, arst_n, state_q == S_UPD, state_q == S_OUT, "update not followed by a result")
	`ASSERT_NEXT(a_tick_skips_div, clk, arst_n, accept && !in_mode, state_q == S_UPD, "tick transaction entered the divider")

endmodule
`default_nettype wire

/* hw/rtl/fac_datapath.sv */
// Datapath of the flood alarm controller: soil divider, grading and alarm timer.
`default_nettype none
`include "assert_macros.svh"
module fac_datapath #(
	parameter int ADC_BITS = fac_pkg::ADC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire fac_pkg::cfg_t                 cfg,
	input  wire fac_pkg::fac_cmd_t             cmd,
	output fac_pkg::fac_sts_t                  sts,
	input  wire logic                          mode,
	input  wire logic [fac_pkg::ECHO_W-1:0]    echo_us,
	input  wire logic [fac_pkg::ADC_W-1:0]     rain_reading,
	input  wire logic [fac_pkg::ADC_W-1:0]     soil_reading,
	output logic [1:0]                         hazard_level,
	output logic                               led_safe,
	output logic                               led_warning,
	output logic                               led_red,
	output logic                               tone_high_on,
	output logic                               tone_low_on,
	output logic [fac_pkg::PCT_W-1:0]          soil_percent,
	output logic [1:0]                         rain_class
);

	localparam int ADC_W = fac_pkg::ADC_W;
	localparam int NUM_W = fac_pkg::NUM_W;
	localparam int QUO_W = fac_pkg::QUO_W;
	localparam int PCT_W = fac_pkg::PCT_W;
	localparam int MS_W  = fac_pkg::MS_W;
	localparam int CNT_W = $clog2(QUO_W);
	localparam logic [ADC_W-1:0] ADC_MASK =
		(ADC_BITS >= ADC_W) ? {ADC_W{1'b1}} : ADC_W'((1 << ADC_BITS) - 1);

	// Item registers captured at acceptance.
	logic             mode_q;
	logic             near_danger_q;
	logic             near_warn_q;
	logic [ADC_W-1:0] rain_s_q;
	logic             neg_q;
	logic             zden_q;
	logic             ovf_q;
	logic [NUM_W-1:0] rem_q;
	logic [NUM_W-1:0] dsh_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;

	// Held state.
	logic [1:0]       level_q;
	logic [PCT_W-1:0] soil_q;
	logic [ADC_W-1:0] rain_q;
	logic [2:0]       step_q;
	logic [MS_W-1:0]  elapsed_q;

	// Capture logic.
	logic [ADC_W-1:0] rain_m;
	logic [ADC_W-1:0] soil_m;
	logic [ADC_W:0]   diff;
	logic [ADC_W:0]   span;
	logic [ADC_W-1:0] diff_mag;
	logic [ADC_W-1:0] span_mag;
	logic [NUM_W-1:0] num_mag;

	always_comb begin
		rain_m   = rain_reading & ADC_MASK;
		soil_m   = soil_reading & ADC_MASK;
		diff     = {1'b0, soil_m} - {1'b0, cfg.soil_dry_reading};
		span     = {1'b0, cfg.soil_wet_reading} - {1'b0, cfg.soil_dry_reading};
		diff_mag = diff[ADC_W] ? ADC_W'(-diff) : diff[ADC_W-1:0];
		span_mag = span[ADC_W] ? ADC_W'(-span) : span[ADC_W-1:0];
		num_mag  = NUM_W'(diff_mag) * NUM_W'(100);
	end

	// One restoring division step per cycle, quotient bit by bit from the top.
	logic [NUM_W:0] trial;
	assign trial        = {1'b0, rem_q} - {1'b0, dsh_q};
	assign sts.div_last = (cnt_q == CNT_W'(QUO_W - 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q        <= mode;
			near_danger_q <= fac_pkg::below_cm(echo_us, cfg.danger_distance_cm);
			near_warn_q   <= fac_pkg::below_cm(echo_us, cfg.warn_distance_cm);
			rain_s_q      <= rain_m;
			neg_q         <= diff[ADC_W] ^ span[ADC_W];
			zden_q        <= (span == '0);
			// A quotient of 256 or more is clamped anyway.
			ovf_q         <= ({1'b0, num_mag} >= {span_mag, {QUO_W{1'b0}}});
			rem_q         <= num_mag;
			dsh_q         <= {span_mag, {(QUO_W-1){1'b0}}};
			quo_q         <= '0;
			cnt_q         <= '0;
		end else if (cmd.div_step) begin
			if (!trial[NUM_W]) begin
				rem_q <= trial[NUM_W-1:0];
			end
			quo_q <= {quo_q[QUO_W-2:0], ~trial[NUM_W]};
			dsh_q <= dsh_q >> 1;
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// Update of the held state.
	logic [PCT_W-1:0] pct_n;
	logic [1:0]       level_n;
	logic [MS_W-1:0]  el_n;
	logic [2:0]       step_n;
	logic [2:0]       step_cur;

	always_comb begin
		priority if (zden_q || neg_q) begin
			pct_n = '0;
		end else if (ovf_q || (quo_q > QUO_W'(fac_pkg::PCT_MAX))) begin
			pct_n = fac_pkg::PCT_MAX;
		end else begin
			pct_n = quo_q[PCT_W-1:0];
		end

		if (mode_q) begin
			priority if (near_danger_q) begin
				level_n = fac_pkg::LVL_DANGER;
			end else if (near_warn_q && ((rain_s_q < cfg.rain_heavy_level) ||
			                             (pct_n > fac_pkg::SOIL_DANGER_PCT))) begin
				level_n = fac_pkg::LVL_DANGER;
			end else if (near_warn_q || (rain_s_q < cfg.rain_light_level) ||
			             (pct_n > fac_pkg::SOIL_WARN_PCT)) begin
				level_n = fac_pkg::LVL_WARN;
			end else begin
				level_n = fac_pkg::LVL_SAFE;
			end
			el_n = elapsed_q;
		end else begin
			level_n = level_q;
			el_n    = (elapsed_q != {MS_W{1'b1}}) ? elapsed_q + MS_W'(1) : elapsed_q;
		end

		step_cur = (step_q > fac_pkg::ALM_GAP2) ? fac_pkg::ALM_START : step_q;
		step_n   = step_cur;
		if (level_n != fac_pkg::LVL_DANGER) begin
			step_n = fac_pkg::ALM_START;
		end else if (el_n > cfg.gap_ms) begin
			unique case (step_cur)
				fac_pkg::ALM_START: begin
					el_n   = '0;
					step_n = fac_pkg::ALM_HIGH;
				end
				fac_pkg::ALM_HIGH: begin
					if (el_n > cfg.tone_ms) begin
						el_n   = '0;
						step_n = fac_pkg::ALM_GAP1;
					end
				end
				fac_pkg::ALM_GAP1: begin
					el_n   = '0;
					step_n = fac_pkg::ALM_LOW;
				end
				fac_pkg::ALM_LOW: begin
					if (el_n > cfg.tone_ms) begin
						el_n   = '0;
						step_n = fac_pkg::ALM_GAP2;
					end
				end
				default: step_n = fac_pkg::ALM_START;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q   <= fac_pkg::LVL_SAFE;
			soil_q    <= '0;
			rain_q    <= ADC_MASK;
			step_q    <= fac_pkg::ALM_START;
			elapsed_q <= '0;
		end else if (cmd.upd) begin
			if (mode_q) begin
				soil_q <= pct_n;
				rain_q <= rain_s_q;
			end
			level_q   <= level_n;
			step_q    <= step_n;
			elapsed_q <= el_n;
		end
	end

	// Outputs come straight from the held state, which is frozen while a result waits.
	always_comb begin
		hazard_level = level_q;
		led_safe     = (level_q == fac_pkg::LVL_SAFE);
		led_warning  = (level_q == fac_pkg::LVL_WARN);
		led_red      = (level_q == fac_pkg::LVL_DANGER);
		tone_high_on = (step_q == fac_pkg::ALM_HIGH);
		tone_low_on  = (step_q == fac_pkg::ALM_LOW);
		soil_percent = soil_q;
		priority if (rain_q < cfg.rain_heavy_level) begin
			rain_class = fac_pkg::RAIN_HEAVY;
		end else if (rain_q < cfg.rain_light_level) begin
			rain_class = fac_pkg::RAIN_MOD;
		end else begin
			rain_class = fac_pkg::RAIN_NONE;
		end
	end

	`ASSERT_IMPLY(a_step_only_in_danger, clk, arst_n, step_q != fac_pkg::ALM_START, level_q == fac_pkg::LVL_DANGER, "alarm step active outside danger")
	`ASSERT_IMPLY(a_soil_clamped, clk, arst_n, 1'b1, soil_q <= fac_pkg::PCT_MAX, "soil percent above one hundred")
	`ASSERT_IMPLY(a_step_in_range, clk, arst_n, 1'b1, step_q <= fac_pkg::ALM_GAP2, "alarm step out of range")

endmodule
`default_nettype wire

/* hw/rtl/flood_alarm_controller.sv */
// Flood alarm controller top level: hazard grading, soil percent and two-tone alarm.
// A tick result goes from acceptance through the update state to the output state; a sample
// result first passes the soil percent divider, which yields one quotient bit a cycle.
// One transaction is in flight at a time: a new one is stalled until the result is taken.
// Asynchronous active-low reset restores the default configuration, a safe hazard,
// zero soil percent, a dry rain reading and a silent alarm at time zero.
`default_nettype none
module flood_alarm_controller #(
	parameter int ADC_BITS = fac_pkg::ADC_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [fac_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [fac_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            mode,
	input  wire logic [fac_pkg::ECHO_W-1:0]      echo_us,
	input  wire logic [fac_pkg::ADC_W-1:0]       rain_reading,
	input  wire logic [fac_pkg::ADC_W-1:0]       soil_reading,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [1:0]                           hazard_level,
	output logic                                 led_safe,
	output logic                                 led_warning,
	output logic                                 led_red,
	output logic                                 tone_high_on,
	output logic                                 tone_low_on,
	output logic [fac_pkg::PCT_W-1:0]            soil_percent,
	output logic [1:0]                           rain_class
);

	fac_pkg::cfg_t     cfg;
	fac_pkg::fac_cmd_t cmd;
	fac_pkg::fac_sts_t sts;

	fac_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	fac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_mode   (mode),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	fac_datapath #(
		.ADC_BITS (ADC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.sts          (sts),
		.mode         (mode),
		.echo_us      (echo_us),
		.rain_reading (rain_reading),
		.soil_reading (soil_reading),
		.hazard_level (hazard_level),
		.led_safe     (led_safe),
		.led_warning  (led_warning),
		.led_red      (led_red),
		.tone_high_on (tone_high_on),
		.tone_low_on  (tone_low_on),
		.soil_percent (soil_percent),
		.rain_class   (rain_class)
	);

endmodule
`default_nettype wire
